// ===== hw/rtl/sobel3_pkg.sv =====
// sobel3_pkg: types, register codes and constants shared by the 3d sobel gradient blocks
// no dependencies; imported by every module of the block
package sobel3_pkg;

   localparam int VOXEL_W     = 16;
   localparam int INDEX_W     = 28;
   localparam int MAG_W       = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int ROW_REG_W   = 9;
   localparam int PLANE_CNT_W = 13;
   localparam int SETTLE_W    = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef logic signed [VOXEL_W-1:0]   voxel_type;
   typedef logic signed [VOXEL_W:0]     diff_type;
   typedef logic signed [VOXEL_W+2:0]   part_type;
   typedef logic signed [VOXEL_W+4:0]   acc_type;
   typedef logic signed [VOXEL_W:0]     resp_type;
   typedef logic [INDEX_W-1:0]          index_type;
   typedef logic [MAG_W-1:0]            mag_type;
   typedef logic [CSR_ADDR_W-1:0]       csr_addr_type;
   typedef logic [PLANE_CNT_W-1:0]      plane_cnt_type;

   localparam csr_addr_type CSR_WIDTH_X  = 2'd0;
   localparam csr_addr_type CSR_HEIGHT_Y = 2'd1;
   localparam csr_addr_type CSR_DEPTH_Z  = 2'd2;

   localparam logic [ROW_REG_W-1:0] WIDTH_X_RESET  = 9'd256;
   localparam logic [ROW_REG_W-1:0] HEIGHT_Y_RESET = 9'd256;
   localparam plane_cnt_type        DEPTH_Z_RESET  = 13'd64;
   localparam plane_cnt_type        PLANES_MIN     = 13'd3;
   localparam plane_cnt_type        PLANES_LIMIT   = 13'd4096;
   localparam int                   DIM_MIN        = 3;

   localparam logic [SETTLE_W-1:0]  SETTLE_CYCLES  = 2'd2;

   typedef struct packed {
      index_type index;
      resp_type  grad_z;
      resp_type  grad_x;
      resp_type  grad_y;
   } grad_item_type;

   typedef struct packed {
      logic          push;
      grad_item_type item;
   } queue_wr_type;

   typedef struct packed {
      logic          empty;
      grad_item_type item;
   } queue_rd_type;

   // 1,2,1 weighting of three differences
   function automatic part_type row_sum(diff_type d0, diff_type d1, diff_type d2);
      row_sum = part_type'(d0) + (part_type'(d1) <<< 1) + part_type'(d2);
   endfunction

   function automatic acc_type total_sum(part_type p0, part_type p1, part_type p2);
      total_sum = acc_type'(p0) + (acc_type'(p1) <<< 1) + acc_type'(p2);
   endfunction

endpackage

// ===== hw/rtl/sobel_3d_gradient_magnitude.sv =====
// sobel_3d_gradient_magnitude: 3x3x3 sobel gradient magnitude over a raster voxel stream
// top level; depends on sobel3_pkg, sobel3_front, sobel3_fifo, sobel3_back
//
// voxels enter in raster order (x fastest, then y, then z) through push/full; a transfer
// happens on a rising edge with push high and full low. results leave through empty/pop:
// the oldest result sits on rsp_voxel_index and rsp_gradient_magnitude while empty is low
// and is taken on an edge with pop high. csr_we writes register csr_index (0 width_x,
// 1 height_y, 2 depth_z) at once; any such write restarts the volume and holds full high
// while the delay lengths are recomputed. reset does the same.
// the result for interior voxel j becomes due when voxel j + 1 + width_x*(1 + height_y)
// is transferred; it then passes the window stage, the partial-sum stage, the queue and
// the back end. border voxels pass at one per cycle while full stays low. interior voxels
// are finished one at a time, each holding the shared squaring multiplier for 3 squares
// and 16 root steps. the 4-entry queue and the result register let the front keep
// accepting while the back works or the receiver holds pop low; once they are full,
// full rises until pop frees a slot.
module sobel_3d_gradient_magnitude
   import sobel3_pkg::*;
#(
   parameter int MAX_ROW_LEN = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_addr_type          csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  push,
   output logic                  full,
   input  voxel_type             req_voxel_value,
   output logic                  empty,
   input  logic                  pop,
   output index_type             rsp_voxel_index,
   output mag_type               rsp_gradient_magnitude
);

   queue_wr_type queue_wr;
   queue_rd_type queue_rd;
   logic         queue_full;
   logic         queue_pop;

   sobel3_front #(
      .MAX_ROW_LEN (MAX_ROW_LEN),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push            (push),
      .full            (full),
      .req_voxel_value (req_voxel_value),
      .queue_full      (queue_full),
      .queue_wr        (queue_wr)
   );

   sobel3_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .queue_wr   (queue_wr),
      .queue_full (queue_full),
      .queue_pop  (queue_pop),
      .queue_rd   (queue_rd)
   );

   sobel3_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .queue_rd               (queue_rd),
      .queue_pop              (queue_pop),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_voxel_index        (rsp_voxel_index),
      .rsp_gradient_magnitude (rsp_gradient_magnitude)
   );

endmodule

// ===== hw/rtl/sobel3_delay.sv =====
// sobel3_delay: circular voxel delay of programmable length held in a single-port memory
// depends on sobel3_pkg
module sobel3_delay
   import sobel3_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic                     en,
   input  logic [$clog2(DEPTH)-1:0] len,
   input  voxel_type                din,
   output voxel_type                dout
);

   localparam int AW = $clog2(DEPTH);

   voxel_type        mem [DEPTH];
   voxel_type        rd_ff;
   logic [AW-1:0]    ptr_ff;
   logic [AW-1:0]    ptr_in;

   always_comb begin
      ptr_in = ptr_ff;
      if (restart) begin
         ptr_in = '0;
      end else if (en) begin
         if (ptr_ff == len - AW'(1)) begin
            ptr_in = '0;
         end else begin
            ptr_in = ptr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff       <= mem[ptr_ff];
         mem[ptr_ff] <= din;
      end
   end

   assign dout = rd_ff;

endmodule

// ===== hw/rtl/sobel3_front.sv =====
// sobel3_front: register file, raster position, 3x3x3 window from row and plane delays,
// and the three shifted sobel responses; depends on sobel3_pkg and sobel3_delay
module sobel3_front
   import sobel3_pkg::*;
#(
   parameter int MAX_ROW_LEN = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  csr_addr_type          csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  push,
   output logic                  full,
   input  voxel_type             req_voxel_value,
   input  logic                  queue_full,
   output queue_wr_type          queue_wr
);

   localparam int ROW_W       = $clog2(MAX_ROW_LEN + 1);
   localparam int ROWS_W      = $clog2(MAX_ROWS + 1);
   localparam int ROW_AW      = $clog2(MAX_ROW_LEN);
   localparam int PLANE_DEPTH = MAX_ROW_LEN * (MAX_ROWS - 2);
   localparam int PLANE_AW    = $clog2(PLANE_DEPTH);
   localparam int DZ_W        = $clog2(MAX_ROW_LEN * MAX_ROWS + 1);

   logic [ROW_REG_W-1:0] width_x_ff, width_x_in;
   logic [ROW_REG_W-1:0] height_y_ff, height_y_in;
   plane_cnt_type        depth_z_ff, depth_z_in;
   logic [SETTLE_W-1:0]  settle_ff, settle_in;
   logic                 restart;

   logic [ROW_W-1:0]     sx;
   logic [ROWS_W-1:0]    sy;
   plane_cnt_type        sz;
   logic [DZ_W-1:0]      dz_ff;
   logic [DZ_W-1:0]      plane_gap;
   logic [PLANE_AW-1:0]  plane_len_ff;
   logic [ROW_W-1:0]     row_gap;
   logic [ROW_AW-1:0]    row_len;

   logic [ROW_W-1:0]     cx_ff, cx_in;
   logic [ROWS_W-1:0]    cy_ff, cy_in;
   plane_cnt_type        cz_ff, cz_in;
   index_type            jcnt_ff, jcnt_in;
   logic                 past_di;
   logic                 emit;
   logic                 accept;

   voxel_type            win0_ff;
   voxel_type            head [9];
   voxel_type            win1_ff [9];
   voxel_type            win2_ff [9];
   voxel_type            tap [3][3][3];

   diff_type             da [3][3];
   diff_type             db [3][3];
   diff_type             dc [3][3];
   part_type             ra [3];
   part_type             rb [3];
   part_type             rc [3];

   logic                 w_vld_ff, w_vld_in;
   index_type            w_idx_ff;
   logic                 p_vld_ff, p_vld_in;
   index_type            p_idx_ff;
   part_type             pa_ff [3];
   part_type             pb_ff [3];
   part_type             pc_ff [3];
   logic                 p_ready;
   logic                 p_load;
   acc_type              acc_z, acc_x, acc_y;

   function automatic logic at_least(plane_cnt_type z, logic [ROWS_W-1:0] y,
                                     logic [ROW_W-1:0] x, logic [1:0] t);
      at_least = (z > PLANE_CNT_W'(t)) ||
                 ((z == PLANE_CNT_W'(t)) &&
                  ((y > ROWS_W'(t)) || ((y == ROWS_W'(t)) && (x >= ROW_W'(t)))));
   endfunction

   // register file
   always_comb begin
      width_x_in  = width_x_ff;
      height_y_in = height_y_ff;
      depth_z_in  = depth_z_ff;
      restart     = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_X: begin
               width_x_in = csr_wdata[ROW_REG_W-1:0];
               restart    = 1'b1;
            end
            CSR_HEIGHT_Y: begin
               height_y_in = csr_wdata[ROW_REG_W-1:0];
               restart     = 1'b1;
            end
            CSR_DEPTH_Z: begin
               depth_z_in = csr_wdata;
               restart    = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      if (restart) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_x_ff  <= WIDTH_X_RESET;
         height_y_ff <= HEIGHT_Y_RESET;
         depth_z_ff  <= DEPTH_Z_RESET;
         settle_ff   <= SETTLE_CYCLES;
      end else begin
         width_x_ff  <= width_x_in;
         height_y_ff <= height_y_in;
         depth_z_ff  <= depth_z_in;
         settle_ff   <= settle_in;
      end
   end

   // saturated geometry and delay lengths
   always_comb begin
      if (width_x_ff < ROW_REG_W'(DIM_MIN)) begin
         sx = ROW_W'(DIM_MIN);
      end else if (width_x_ff > MAX_ROW_LEN) begin
         sx = ROW_W'(MAX_ROW_LEN);
      end else begin
         sx = ROW_W'(width_x_ff);
      end
      if (height_y_ff < ROW_REG_W'(DIM_MIN)) begin
         sy = ROWS_W'(DIM_MIN);
      end else if (height_y_ff > MAX_ROWS) begin
         sy = ROWS_W'(MAX_ROWS);
      end else begin
         sy = ROWS_W'(height_y_ff);
      end
      if (depth_z_ff < PLANES_MIN) begin
         sz = PLANES_MIN;
      end else if (depth_z_ff > PLANES_LIMIT) begin
         sz = PLANES_LIMIT;
      end else begin
         sz = depth_z_ff;
      end
      row_gap   = sx - ROW_W'(1);
      row_len   = row_gap[ROW_AW-1:0];
      plane_gap = dz_ff - (DZ_W'(sx) << 1) - DZ_W'(1);
   end

   always_ff @(posedge clock) begin
      dz_ff        <= DZ_W'(sx) * DZ_W'(sy);
      plane_len_ff <= plane_gap[PLANE_AW-1:0];
   end

   // raster position
   assign p_ready = !p_vld_ff || !queue_full;
   assign p_load  = w_vld_ff && p_ready;
   assign full    = (settle_ff != '0) || (w_vld_ff && !p_ready);
   assign accept  = push && !full;
   assign past_di = at_least(cz_ff, cy_ff, cx_ff, 2'd1);
   assign emit    = at_least(cz_ff, cy_ff, cx_ff, 2'd2);

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      jcnt_in = jcnt_ff;
      if (restart) begin
         cx_in   = '0;
         cy_in   = '0;
         cz_in   = '0;
         jcnt_in = '0;
      end else if (accept) begin
         jcnt_in = past_di ? jcnt_ff + INDEX_W'(1) : '0;
         if (cx_ff == sx - ROW_W'(1)) begin
            cx_in = '0;
            if (cy_ff == sy - ROWS_W'(1)) begin
               cy_in = '0;
               if (cz_ff == sz - PLANE_CNT_W'(1)) begin
                  cz_in = '0;
               end else begin
                  cz_in = cz_ff + PLANE_CNT_W'(1);
               end
            end else begin
               cy_in = cy_ff + ROWS_W'(1);
            end
         end else begin
            cx_in = cx_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         cz_ff   <= '0;
         jcnt_ff <= '0;
      end else begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         jcnt_ff <= jcnt_in;
      end
   end

   // window: stream r = 3*plane + row, each stream one row or one plane gap later
   assign head[0] = win0_ff;

   for (genvar r = 1; r < 9; r++) begin : g_stream
      if (r % 3 == 0) begin : g_plane
         sobel3_delay #(
            .DEPTH (PLANE_DEPTH)
         ) u_delay (
            .clock   (clock),
            .reset   (reset),
            .restart (restart),
            .en      (accept),
            .len     (plane_len_ff),
            .din     (head[r-1]),
            .dout    (head[r])
         );
      end else begin : g_row
         sobel3_delay #(
            .DEPTH (MAX_ROW_LEN)
         ) u_delay (
            .clock   (clock),
            .reset   (reset),
            .restart (restart),
            .en      (accept),
            .len     (row_len),
            .din     (head[r-1]),
            .dout    (head[r])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win0_ff <= req_voxel_value;
         for (int r = 0; r < 9; r++) begin
            win1_ff[r] <= head[r];
            win2_ff[r] <= win1_ff[r];
         end
      end
   end

   always_comb begin
      for (int ez = 0; ez < 3; ez++) begin
         for (int ey = 0; ey < 3; ey++) begin
            tap[ez][ey][0] = head[ez*3+ey];
            tap[ez][ey][1] = win1_ff[ez*3+ey];
            tap[ez][ey][2] = win2_ff[ez*3+ey];
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int e = 0; e < 3; e++) begin
            da[i][e] = diff_type'(tap[0][i][e]) - diff_type'(tap[2][i][e]);
            db[i][e] = diff_type'(tap[i][e][0]) - diff_type'(tap[i][e][2]);
            dc[i][e] = diff_type'(tap[i][0][e]) - diff_type'(tap[i][2][e]);
         end
         ra[i] = row_sum(da[i][0], da[i][1], da[i][2]);
         rb[i] = row_sum(db[i][0], db[i][1], db[i][2]);
         rc[i] = row_sum(dc[i][0], dc[i][1], dc[i][2]);
      end
   end

   // window stage and partial-sum stage
   always_comb begin
      if (accept) begin
         w_vld_in = emit;
      end else if (p_load) begin
         w_vld_in = 1'b0;
      end else begin
         w_vld_in = w_vld_ff;
      end
      if (p_load) begin
         p_vld_in = 1'b1;
      end else if (queue_wr.push) begin
         p_vld_in = 1'b0;
      end else begin
         p_vld_in = p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
      end else begin
         w_vld_ff <= w_vld_in;
         p_vld_ff <= p_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         w_idx_ff <= jcnt_ff;
      end
      if (p_load) begin
         p_idx_ff <= w_idx_ff;
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= ra[i];
            pb_ff[i] <= rb[i];
            pc_ff[i] <= rc[i];
         end
      end
   end

   always_comb begin
      acc_z                = total_sum(pa_ff[0], pa_ff[1], pa_ff[2]);
      acc_x                = total_sum(pb_ff[0], pb_ff[1], pb_ff[2]);
      acc_y                = total_sum(pc_ff[0], pc_ff[1], pc_ff[2]);
      queue_wr.push        = p_vld_ff && !queue_full;
      queue_wr.item.index  = p_idx_ff;
      queue_wr.item.grad_z = acc_z[VOXEL_W+4:4];
      queue_wr.item.grad_x = acc_x[VOXEL_W+4:4];
      queue_wr.item.grad_y = acc_y[VOXEL_W+4:4];
   end

endmodule

// ===== hw/rtl/sobel3_fifo.sv =====
// sobel3_fifo: short queue of sobel responses between the front and the back
// depends on sobel3_pkg
module sobel3_fifo
   import sobel3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type queue_wr,
   output logic         queue_full,
   input  logic         queue_pop,
   output queue_rd_type queue_rd
);

   grad_item_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign queue_full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign queue_rd.empty = (count_ff == '0);
   assign queue_rd.item  = slot_ff[rd_ptr_ff];
   assign do_push        = queue_wr.push && !queue_full;
   assign do_pop         = queue_pop && !queue_rd.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= queue_wr.item;
      end
   end

endmodule

// ===== hw/rtl/sobel3_back.sv =====
// sobel3_back: sum of squares and rounded root of mean square with one shared multiplier,
// plus the result register; depends on sobel3_pkg
module sobel3_back
   import sobel3_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_rd_type queue_rd,
   output logic         queue_pop,
   output logic         empty,
   input  logic         pop,
   output index_type    rsp_voxel_index,
   output mag_type      rsp_gradient_magnitude
);

   localparam int SSQ_W = 2 * MAG_W + 2;
   localparam int OP_W  = MAG_W + 1;
   localparam int CMP_W = SSQ_W + 2;
   localparam int BIT_W = $clog2(MAG_W);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SQUARE   = 3'd1;
   localparam logic [2:0] ST_ROOT_MUL = 3'd2;
   localparam logic [2:0] ST_ROOT_CMP = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   mag_type           mag_ff [3];
   index_type         idx_ff;
   logic [SSQ_W-1:0]  ssq_ff, ssq_in;
   logic [SSQ_W-1:0]  sq_ff;
   mag_type           root_ff, root_in;
   logic              res_vld_ff, res_vld_in;
   index_type         res_idx_ff;
   mag_type           res_mag_ff;

   logic              take;
   logic              load_res;
   mag_type           cand_root;
   logic [OP_W-1:0]   cand_t;
   logic [OP_W-1:0]   mul_op;
   logic [SSQ_W-1:0]  prod;
   logic              fits;

   function automatic mag_type abs_resp(resp_type v);
      resp_type m;
      m        = v[VOXEL_W] ? -v : v;
      abs_resp = m[MAG_W-1:0];
   endfunction

   always_comb begin
      cand_root = root_ff | (MAG_W'(1) << bit_ff);
      cand_t    = {cand_root, 1'b0} - OP_W'(1);
      mul_op    = (state_ff == ST_SQUARE) ? {1'b0, mag_ff[step_ff]} : cand_t;
      prod      = mul_op * mul_op;
      fits      = {ssq_ff, 2'b00} >= (CMP_W'(sq_ff) + (CMP_W'(sq_ff) << 1));
      take      = (state_ff == ST_IDLE) && !queue_rd.empty;
      load_res  = (state_ff == ST_DONE) && (!res_vld_ff || pop);
      queue_pop = take;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      ssq_in   = ssq_ff;
      root_in  = root_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               step_in  = 2'd0;
               ssq_in   = '0;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            ssq_in = ssq_ff + prod;
            if (step_ff == 2'd2) begin
               root_in  = '0;
               bit_in   = BIT_W'(MAG_W - 1);
               state_in = ST_ROOT_MUL;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_ROOT_MUL: begin
            state_in = ST_ROOT_CMP;
         end
         ST_ROOT_CMP: begin
            if (fits) begin
               root_in = cand_root;
            end
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = ST_ROOT_MUL;
            end
         end
         ST_DONE: begin
            if (load_res) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_res) begin
         res_vld_in = 1'b1;
      end else if (pop && res_vld_ff) begin
         res_vld_in = 1'b0;
      end else begin
         res_vld_in = res_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         res_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         res_vld_ff <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      bit_ff  <= bit_in;
      ssq_ff  <= ssq_in;
      root_ff <= root_in;
      if (state_ff == ST_ROOT_MUL) begin
         sq_ff <= prod;
      end
      if (take) begin
         idx_ff    <= queue_rd.item.index;
         mag_ff[0] <= abs_resp(queue_rd.item.grad_z);
         mag_ff[1] <= abs_resp(queue_rd.item.grad_x);
         mag_ff[2] <= abs_resp(queue_rd.item.grad_y);
      end
      if (load_res) begin
         res_idx_ff <= idx_ff;
         res_mag_ff <= root_ff;
      end
   end

   assign empty                  = !res_vld_ff;
   assign rsp_voxel_index        = res_idx_ff;
   assign rsp_gradient_magnitude = res_mag_ff;

endmodule

// ===== hw/rtl/sobel3_checker.sv =====
// sobel3_checker: port-level assertions for sobel_3d_gradient_magnitude, bound to the top
// depends on sobel3_pkg
module sobel3_checker
   import sobel3_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         csr_we,
   input csr_addr_type csr_index,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input index_type    rsp_voxel_index,
   input mag_type      rsp_gradient_magnitude
);

   // after reset nothing is waiting and no voxel is taken while lengths settle
   a_reset_state: assert property (@(posedge clock)
      reset |=> empty && full)
      else $error("reset did not leave the block empty and stalled");

   // a register write stalls the input while the delay lengths settle
   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CSR_WIDTH_X || csr_index == CSR_HEIGHT_Y ||
                  csr_index == CSR_DEPTH_Z)) |=> full ##1 full)
      else $error("input accepted before delay lengths settled");

   // a waiting result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_voxel_index) &&
                            $stable(rsp_gradient_magnitude)))
      else $error("waiting result changed before transfer");

endmodule

bind sobel_3d_gradient_magnitude sobel3_checker u_checker (.*);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for sobel_3d_gradient_magnitude on random and directed volumes
// depends on sobel3_pkg and the rtl of the block; holds its own gradient predictor and queue
timeunit 1ns;
timeprecision 1ps;

import sobel3_pkg::*;

class sobel_scoreboard;
   localparam int LINE_LEN = 131586;
   typedef struct {
      index_type index;
      mag_type   mag;
   } grad_result_type;

   logic signed [15:0] voxel_line [LINE_LEN];
   logic [8:0]         width_x;
   logic [8:0]         height_y;
   logic [12:0]        depth_z;
   longint             voxel_pos;
   grad_result_type    due_grads[$];
   int                 errors;
   int                 checked;
   int                 voxels;
   int                 tap_u[9] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
   int                 tap_v[9] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
   int                 tap_w[9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

   function new();
      width_x = WIDTH_X_RESET;
      height_y = HEIGHT_Y_RESET;
      depth_z = DEPTH_Z_RESET;
      voxel_pos = 0;
   endfunction

   function void write_reg(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      case (addr)
         CSR_WIDTH_X: width_x = data[8:0];
         CSR_HEIGHT_Y: height_y = data[8:0];
         CSR_DEPTH_Z: depth_z = data;
         default: return;
      endcase
      voxel_pos = 0;
   endfunction

   function longint clamp_dim(longint v, longint hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function longint tap_value(longint q, longint k, longint cur);
      if (q == k) return cur;
      return longint'(voxel_line[q % LINE_LEN]);
   endfunction

   function longint sobel_resp(longint j, longint k, longint cur, longint s, longint u,
                               longint v);
      longint acc;
      longint base;
      acc = 0;
      for (int m = 0; m < 9; m++) begin
         base = j + u * tap_u[m] + v * tap_v[m];
         acc += tap_w[m] * (tap_value(base + s, k, cur) - tap_value(base - s, k, cur));
      end
      return acc >>> 4;
   endfunction

   function mag_type rounded_rms(longint unsigned ssq);
      longint unsigned lo, hi, mid, t;
      lo = 0;
      hi = 65535;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 2 * mid - 1;
         if (4 * ssq >= 3 * t * t) lo = mid;
         else hi = mid - 1;
      end
      return mag_type'(lo);
   endfunction

   function void note_voxel(voxel_type value);
      longint sx, sy, sz, n, dy, dz, di, k, cur, j, a, b, c;
      grad_result_type res;
      sx = clamp_dim(width_x, 256);
      sy = clamp_dim(height_y, 256);
      sz = clamp_dim(depth_z, 4096);
      n = sx * sy * sz;
      dy = sx;
      dz = sx * sy;
      di = 1 + dy + dz;
      k = voxel_pos;
      cur = longint'(value);
      if (k >= 2 * di && k < n) begin
         j = k - di;
         a = sobel_resp(j, k, cur, dz, 1, dy);
         b = sobel_resp(j, k, cur, 1, dz, dy);
         c = sobel_resp(j, k, cur, dy, 1, dz);
         res.index = index_type'(j);
         res.mag = rounded_rms(longint'(a * a + b * b + c * c));
         due_grads.push_back(res);
      end
      voxel_line[k % LINE_LEN] = value;
      k++;
      if (k >= n) k = 0;
      voxel_pos = k;
      voxels++;
   endfunction

   function void check_result(index_type index, mag_type mag);
      grad_result_type exp_r;
      checked++;
      if (due_grads.size() == 0) begin
         $display("%0t: unexpected result index %0d magnitude %0d", $time, index, mag);
         errors++;
         return;
      end
      exp_r = due_grads.pop_front();
      if (exp_r.index !== index) begin
         $display("%0t: voxel_index expected %0d actual %0d", $time, exp_r.index, index);
         errors++;
      end
      if (exp_r.mag !== mag) begin
         $display("%0t: gradient_magnitude expected %0d actual %0d (index %0d)", $time,
                  exp_r.mag, mag, exp_r.index);
         errors++;
      end
   endfunction
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam csr_addr_type CSR_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_addr_type          csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  push;
   logic                  full;
   voxel_type             req_voxel_value;
   logic                  empty;
   logic                  pop;
   index_type             rsp_voxel_index;
   mag_type               rsp_gradient_magnitude;

   sobel_scoreboard sb;
   bit              quiet;
   int              phases;

   sobel_3d_gradient_magnitude dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .push(push), .full(full), .req_voxel_value(req_voxel_value),
      .empty(empty), .pop(pop), .rsp_voxel_index(rsp_voxel_index),
      .rsp_gradient_magnitude(rsp_gradient_magnitude)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !quiet && ($urandom_range(0, 99) < 31);
   endfunction

   task automatic write_reg(csr_addr_type addr, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= addr;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(addr, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one voxel transfer, push left high for a following voxel
   task automatic send_voxel(voxel_type value);
      @(negedge clock);
      while (take_gap()) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_voxel_value <= value;
      @(posedge clock);
      while (full) @(posedge clock);
      sb.note_voxel(value);
   endtask

   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (sb.due_grads.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic voxel_type pick_voxel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return voxel_type'($urandom);
      if (r < 70) return voxel_type'($signed($urandom_range(0, 32)) - 16);
      if (r < 85) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      return voxel_type'($signed($urandom_range(0, 2000)) - 1000);
   endfunction

   task automatic run_volume(logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h,
                             logic [CSR_DATA_W-1:0] d, int count);
      write_reg(CSR_WIDTH_X, w);
      write_reg(CSR_HEIGHT_Y, h);
      write_reg(CSR_DEPTH_Z, d);
      for (int i = 0; i < count; i++) send_voxel(pick_voxel());
      drain();
      phases++;
   endtask

   // result side: pop stalls at random
   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (pop && !empty) sb.check_result(rsp_voxel_index, rsp_gradient_magnitude);
         @(negedge clock);
         pop <= !take_gap();
      end
   end

   initial begin
      #50ms;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int sx, sy, sz, n, cnt;
      sb = new();
      quiet = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH_X;
      csr_wdata = '0;
      push = 1'b0;
      req_voxel_value = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default geometry, no interior voxel reachable
      send_voxel(16'sh7fff);
      send_voxel(16'sh8000);
      send_voxel(16'sh0000);
      send_voxel(-16'sd1);
      drain();
      // smallest volume, alternating extremes
      write_reg(CSR_WIDTH_X, 13'd3);
      write_reg(CSR_HEIGHT_Y, 13'd3);
      write_reg(CSR_DEPTH_Z, 13'd3);
      for (int i = 0; i < 14; i++) send_voxel(i % 2 ? 16'sh7fff : 16'sh8000);
      drain();
      // unused register index leaves the volume position alone
      write_reg(CSR_UNUSED, 13'h1fff);
      for (int i = 0; i < 13; i++) send_voxel(i % 3 ? 16'sh8000 : 16'sh7fff);
      drain();

      // register extremes and saturation
      run_volume(13'd0, 13'd1, 13'd2, 40);
      run_volume(13'd511, 13'd3, 13'd3, 120);
      run_volume(13'd3, 13'h1fff, 13'd0, 120);
      quiet = 1'b1;
      run_volume(13'd3, 13'd3, 13'h1fff, 150);
      run_volume(13'd3, 13'd3, 13'd4096, 60);
      quiet = 1'b0;

      // random small volumes, some wrapping into the next volume
      while (sb.voxels < 1700) begin
         sx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 6);
         sy = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 6);
         sz = $urandom_range(0, 9) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 6);
         n = (sx < 3 ? 3 : sx) * (sy < 3 ? 3 : sy) * (sz < 3 ? 3 : sz);
         cnt = $urandom_range(0, 3) == 0 ? n + $urandom_range(1, n) : n;
         if (cnt > 1760 - sb.voxels) cnt = 1760 - sb.voxels;
         run_volume(13'(sx), 13'(sy), 13'(sz), cnt);
      end

      $display("covered %0d voxels in %0d volume settings, %0d gradients compared",
               sb.voxels, phases, sb.checked);
      if (sb.errors == 0 && sb.due_grads.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
